// ----- rtl/weighted_priority_process_scheduler_defines.svh -----
// Assertion macros for the scheduler RTL.
`ifndef WEIGHTED_PRIORITY_PROCESS_SCHEDULER_DEFINES_SVH
`define WEIGHTED_PRIORITY_PROCESS_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define WPPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");
// Next-cycle implication.
`define WPPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define WPPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WPPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/wpps_pkg.sv -----
`timescale 1ns / 1ps
package wpps_pkg;
    localparam int NUM_SLOTS_DEF   = 16;
    localparam int PRIO_LEVELS_DEF = 3;
    localparam int QUEUE_DEPTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int NPRIO_W  = 2;
    localparam int RAND_W   = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SCHEDULE = 3'd0,
        CMD_CREATE   = 3'd1,
        CMD_KILL     = 3'd2,
        CMD_SET_PRIO = 3'd3,
        CMD_BLOCK    = 3'd4,
        CMD_WAKE     = 3'd5,
        CMD_SLEEP    = 3'd6,
        CMD_UNSLEEP  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        PROC_READY    = 3'd0,
        PROC_RUNNING  = 3'd1,
        PROC_BLOCKED  = 3'd2,
        PROC_SLEEPING = 3'd3,
        PROC_TERM     = 3'd4
    } t_pstate;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK   = 2'd0,
        STS_ERR  = 2'd1,
        STS_DROP = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        FS_IDLE, FS_EXEC, FS_SCAN, FS_POP, FS_CHECK, FS_FINISH, FS_OUT
    } t_fsm;

    typedef enum logic [2:0] {
        DP_NONE, DP_LOAD, DP_EXEC, DP_SCAN, DP_POP, DP_CHECK, DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_ctrl;

    typedef struct packed {
        logic is_sched;
        logic is_create;
        logic hit;
        logic scan_last;
        logic q_empty;
        logic last_level;
    } t_stat;
endpackage

// ----- rtl/wpps_if.sv -----
`timescale 1ns / 1ps
interface wpps_cmd_if import wpps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  slot;
    logic [NPRIO_W-1:0] new_priority;
    logic [RAND_W-1:0]  rand_draw;
    logic               sleep_expired;
    modport source (output valid, cmd, slot, new_priority, rand_draw, sleep_expired,
                    input ready);
    modport sink   (input valid, cmd, slot, new_priority, rand_draw, sleep_expired,
                    output ready);
endinterface

interface wpps_res_if import wpps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic [SLOT_W-1:0]   running_slot;
    modport source (output valid, status, result_slot, running_slot, input ready);
    modport sink   (input valid, status, result_slot, running_slot, output ready);
endinterface

// ----- rtl/weighted_priority_process_scheduler.sv -----
// Kill, priority, block, wake, sleep and unsleep go from FS_EXEC straight to FS_OUT for their word.
// Create: FS_EXEC, then the one-a-cycle free-slot scan over k slots (k = 1..NUM_SLOTS-1).
// Schedule: FS_POP and FS_CHECK per queue entry popped, FS_POP per empty level passed; the queue
// RAM read port sets the pop/check step. One command in flight; next word taken after the result.
// Reset: synchronous, active low; slot 0 ready, others terminated, queues empty, running 0.
`timescale 1ns / 1ps
`include "weighted_priority_process_scheduler_defines.svh"
module weighted_priority_process_scheduler import wpps_pkg::*; #(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int PRIO_LEVELS = PRIO_LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wpps_cmd_if.sink    i_cmd_ch,
    wpps_res_if.source  o_res_ch
);
    t_ctrl ctrl;
    t_stat stat;
    logic  in_ready, out_valid;

    // Controller: sequence one command word at a time through the datapath.
    wpps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd_ch.valid),
        .i_out_ready (o_res_ch.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_ctrl      (ctrl)
    );

    // Datapath: slot table, ready queues in RAM, result registers.
    wpps_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .PRIO_LEVELS (PRIO_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_cmd           (i_cmd_ch.cmd),
        .i_slot          (i_cmd_ch.slot),
        .i_new_priority  (i_cmd_ch.new_priority),
        .i_rand_draw     (i_cmd_ch.rand_draw),
        .i_sleep_expired (i_cmd_ch.sleep_expired),
        .o_stat          (stat),
        .o_status        (o_res_ch.status),
        .o_result_slot   (o_res_ch.result_slot),
        .o_running_slot  (o_res_ch.running_slot)
    );

    assign i_cmd_ch.ready = in_ready;
    assign o_res_ch.valid = out_valid;

    // Result word never carries an undefined status code.
    `WPPS_ASSERT_IMP(a_status_code, i_clk, i_rst_n, out_valid, o_res_ch.status <= 2'(STS_DROP))
    // Hold off new commands while a result word waits.
    `WPPS_ASSERT_IMP(a_one_in_flight, i_clk, i_rst_n, out_valid, !in_ready)
    // Once the result word is taken, accept the next command straight away.
    `WPPS_ASSERT_NXT(a_back_to_idle, i_clk, i_rst_n, out_valid && o_res_ch.ready, in_ready)
endmodule

// ----- rtl/wpps_ctrl.sv -----
`timescale 1ns / 1ps
module wpps_ctrl import wpps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_ctrl o_ctrl
);
    t_fsm r_fsm, n_fsm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= FS_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            FS_IDLE: begin
                if (i_in_valid) n_fsm = FS_EXEC;
            end
            FS_EXEC: begin
                if (i_stat.is_create)     n_fsm = FS_SCAN;
                else if (i_stat.is_sched) n_fsm = FS_POP;
                else                      n_fsm = FS_OUT;
            end
            FS_SCAN: begin
                if (i_stat.hit || i_stat.scan_last) n_fsm = FS_OUT;
            end
            FS_POP: begin
                if (!i_stat.q_empty)        n_fsm = FS_CHECK;
                else if (i_stat.last_level) n_fsm = FS_FINISH;
            end
            FS_CHECK:  n_fsm = i_stat.hit ? FS_FINISH : FS_POP;
            FS_FINISH: n_fsm = FS_OUT;
            FS_OUT: begin
                if (i_out_ready) n_fsm = FS_IDLE;
            end
            default:   n_fsm = FS_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctrl.op   = DP_NONE;
        unique case (r_fsm)
            FS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctrl.op = DP_LOAD;
            end
            FS_EXEC:   o_ctrl.op = DP_EXEC;
            FS_SCAN:   o_ctrl.op = DP_SCAN;
            FS_POP:    o_ctrl.op = DP_POP;
            FS_CHECK:  o_ctrl.op = DP_CHECK;
            FS_FINISH: o_ctrl.op = DP_FINISH;
            FS_OUT:    o_out_valid = 1'b1;
            default:   o_ctrl.op = DP_NONE;
        endcase
    end
endmodule

// ----- rtl/wpps_datapath.sv -----
`timescale 1ns / 1ps
module wpps_datapath import wpps_pkg::*; #(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int PRIO_LEVELS = PRIO_LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl               i_ctrl,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [NPRIO_W-1:0]  i_new_priority,
    input  logic [RAND_W-1:0]   i_rand_draw,
    input  logic                i_sleep_expired,
    output t_stat               o_stat,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_result_slot,
    output logic [SLOT_W-1:0]   o_running_slot
);
    localparam int SW = $clog2(NUM_SLOTS);
    localparam int PW = $clog2(PRIO_LEVELS);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(PRIO_LEVELS * QUEUE_DEPTH);

    t_pstate          r_state [NUM_SLOTS];
    t_pstate          r_saved [NUM_SLOTS];
    logic [PW-1:0]    r_prio  [NUM_SLOTS];
    logic [QW-1:0]    r_head  [PRIO_LEVELS];
    logic [QW-1:0]    r_tail  [PRIO_LEVELS];
    logic [CW-1:0]    r_count [PRIO_LEVELS];
    logic [SW-1:0]    mem     [PRIO_LEVELS*QUEUE_DEPTH];
    logic [SW-1:0]    r_cur, r_idx, r_chosen, r_rd;
    logic [PW-1:0]    r_p, r_n;
    t_status          r_status;
    logic             r_drop;
    logic [SLOT_W-1:0] r_res;
    t_cmd             r_cmd;
    logic [SLOT_W-1:0] r_slot;
    logic [NPRIO_W-1:0] r_np;
    logic [RAND_W-1:0] r_rv;
    logic             r_exp;

    logic [SW-1:0] rd_idx, wr_idx, push_s;
    logic [PW-1:0] push_p, pr_val, start_p;
    t_pstate       rs, rsv, st_val, sv_val, tgt, nst;
    logic [PW-1:0] rp;
    logic          inr, st_we, sv_we, pr_we, push_en, q_full, err, hit, q_empty, s_done;
    logic [AW-1:0] waddr, raddr;
    logic [8:0]    acc;

    // Weighted start level: weight (levels - p)^2 for level p; draws past the total go to the last level.
    always_comb begin
        acc     = '0;
        s_done  = 1'b0;
        start_p = PW'(PRIO_LEVELS - 1);
        for (int p = 0; p < PRIO_LEVELS; p++) begin
            acc = acc + 9'((PRIO_LEVELS - p) * (PRIO_LEVELS - p));
            if (!s_done && ({5'b0, r_rv} < acc)) begin
                start_p = PW'(p);
                s_done  = 1'b1;
            end
        end
    end

    always_comb begin
        inr     = 32'(r_slot) < NUM_SLOTS;
        rd_idx  = SW'(r_slot);
        if (i_ctrl.op == DP_EXEC && r_cmd == CMD_SCHEDULE) rd_idx = r_cur;
        else if (i_ctrl.op == DP_SCAN)                     rd_idx = r_idx;
        else if (i_ctrl.op == DP_CHECK)                    rd_idx = r_rd;
        rs      = r_state[rd_idx];
        rsv     = r_saved[rd_idx];
        rp      = r_prio[rd_idx];
        wr_idx  = (i_ctrl.op == DP_FINISH) ? r_chosen : rd_idx;
        tgt     = (r_cmd == CMD_BLOCK) ? PROC_BLOCKED : PROC_SLEEPING;
        nst     = rsv;
        st_we   = 1'b0;
        st_val  = PROC_READY;
        sv_we   = 1'b0;
        sv_val  = PROC_TERM;
        pr_we   = 1'b0;
        pr_val  = '0;
        push_en = 1'b0;
        push_p  = rp;
        push_s  = rd_idx;
        err     = 1'b0;
        hit     = 1'b0;
        unique case (i_ctrl.op)
            DP_EXEC: begin
                unique case (r_cmd)
                    CMD_SCHEDULE: begin
                        // Set the running slot ready and hand it back to its queue; slot 0 is not queued.
                        if (rs == PROC_RUNNING) begin
                            st_we   = 1'b1;
                            push_en = (r_cur != '0);
                        end
                    end
                    CMD_CREATE: ;
                    CMD_KILL: begin
                        if (!inr || r_slot == '0 || rs == PROC_TERM) err = 1'b1;
                        else begin
                            st_we  = 1'b1;
                            st_val = PROC_TERM;
                        end
                    end
                    CMD_SET_PRIO: begin
                        if (!inr || 32'(r_np) >= PRIO_LEVELS) err = 1'b1;
                        else if (rp != PW'(r_np)) begin
                            pr_we   = 1'b1;
                            pr_val  = PW'(r_np);
                            push_p  = PW'(r_np);
                            push_en = (rs == PROC_READY);
                        end
                    end
                    CMD_BLOCK, CMD_SLEEP: begin
                        if (!inr || rs == PROC_TERM || rs == tgt) err = 1'b1;
                        else begin
                            sv_we  = 1'b1;
                            sv_val = (rs == PROC_RUNNING) ? PROC_READY : rs;
                            st_we  = 1'b1;
                            st_val = tgt;
                        end
                    end
                    CMD_WAKE: begin
                        if (!inr || rs != PROC_BLOCKED) err = 1'b1;
                        else begin
                            if (rsv == PROC_SLEEPING) nst = r_exp ? PROC_READY : PROC_SLEEPING;
                            st_we   = 1'b1;
                            st_val  = nst;
                            push_en = (nst == PROC_READY);
                        end
                    end
                    CMD_UNSLEEP: begin
                        if (!inr || rs != PROC_SLEEPING) err = 1'b1;
                        else begin
                            st_we   = 1'b1;
                            st_val  = rsv;
                            push_en = (rsv == PROC_READY);
                        end
                    end
                    default: err = 1'b1;
                endcase
            end
            DP_SCAN: begin
                if (rs == PROC_TERM) begin
                    hit     = 1'b1;
                    st_we   = 1'b1;
                    sv_we   = 1'b1;
                    pr_we   = 1'b1;
                    push_en = 1'b1;
                    push_p  = '0;
                end else if (r_idx == SW'(NUM_SLOTS - 1)) begin
                    err = 1'b1;
                end
            end
            DP_CHECK: hit = (rp == r_p) && (rs == PROC_READY);
            DP_FINISH: begin
                st_we  = 1'b1;
                st_val = PROC_RUNNING;
            end
            DP_NONE, DP_LOAD, DP_POP: ;
            default: ;
        endcase
    end

    assign q_full  = 32'(r_count[push_p]) >= QUEUE_DEPTH;
    assign q_empty = (r_count[r_p] == '0);
    assign waddr   = AW'(push_p) * AW'(QUEUE_DEPTH) + AW'(r_tail[push_p]);
    assign raddr   = AW'(r_p) * AW'(QUEUE_DEPTH) + AW'(r_head[r_p]);

    assign o_stat.is_sched   = (r_cmd == CMD_SCHEDULE);
    assign o_stat.is_create  = (r_cmd == CMD_CREATE);
    assign o_stat.hit        = hit;
    assign o_stat.scan_last  = (r_idx == SW'(NUM_SLOTS - 1));
    assign o_stat.q_empty    = q_empty;
    assign o_stat.last_level = (r_n == PW'(PRIO_LEVELS - 1));

    assign o_status       = (r_status == STS_OK && r_drop) ? STS_DROP : r_status;
    assign o_result_slot  = r_res;
    assign o_running_slot = SLOT_W'(r_cur);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == DP_LOAD) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_slot <= i_slot;
            r_np   <= i_new_priority;
            r_rv   <= i_rand_draw;
            r_exp  <= i_sleep_expired;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en && !q_full) mem[waddr] <= push_s;
        if (i_ctrl.op == DP_POP && !q_empty) r_rd <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_state[i] <= (i == 0) ? PROC_READY : PROC_TERM;
                r_saved[i] <= PROC_TERM;
                r_prio[i]  <= '0;
            end
            for (int q = 0; q < PRIO_LEVELS; q++) begin
                r_head[q]  <= '0;
                r_tail[q]  <= '0;
                r_count[q] <= '0;
            end
            r_cur    <= '0;
            r_idx    <= '0;
            r_chosen <= '0;
            r_p      <= '0;
            r_n      <= '0;
            r_status <= STS_OK;
            r_drop   <= 1'b0;
            r_res    <= '0;
        end else begin
            if (st_we) r_state[wr_idx] <= st_val;
            if (sv_we) r_saved[wr_idx] <= sv_val;
            if (pr_we) r_prio[wr_idx]  <= pr_val;
            if (push_en) begin
                if (q_full) r_drop <= 1'b1;
                else begin
                    r_tail[push_p]  <= (32'(r_tail[push_p]) == QUEUE_DEPTH - 1) ? '0
                                       : r_tail[push_p] + 1'b1;
                    r_count[push_p] <= r_count[push_p] + 1'b1;
                end
            end
            if (err) r_status <= STS_ERR;
            unique case (i_ctrl.op)
                DP_LOAD: begin
                    r_status <= STS_OK;
                    r_drop   <= 1'b0;
                    r_idx    <= SW'(1);
                    r_chosen <= '0;
                    r_res    <= '0;
                end
                DP_EXEC: begin
                    r_p <= start_p;
                    r_n <= '0;
                end
                DP_SCAN: begin
                    if (hit) r_res <= SLOT_W'(r_idx);
                    else     r_idx <= r_idx + 1'b1;
                end
                DP_POP: begin
                    if (q_empty) begin
                        // Move on to the next level, wrapping round.
                        r_p <= (r_p == PW'(PRIO_LEVELS - 1)) ? '0 : r_p + 1'b1;
                        r_n <= r_n + 1'b1;
                    end else begin
                        r_head[r_p]  <= (32'(r_head[r_p]) == QUEUE_DEPTH - 1) ? '0
                                        : r_head[r_p] + 1'b1;
                        r_count[r_p] <= r_count[r_p] - 1'b1;
                    end
                end
                DP_CHECK: begin
                    if (hit) r_chosen <= r_rd;
                end
                DP_FINISH: begin
                    r_cur <= r_chosen;
                    r_res <= SLOT_W'(r_chosen);
                end
                DP_NONE: ;
                default: ;
            endcase
        end
    end
endmodule
